>>> src/smmc_pkg.sv
// Shared constants for the sensor min/max calibration block.
package smmc_pkg;

    localparam int CHANNEL_BITS   = 3;
    localparam int CHANNEL_CODES  = 1 << CHANNEL_BITS;
    localparam int INVERT_BITS    = 6;
    localparam int VALUE_BITS     = 16;
    localparam int VALUE_MAX      = 32767;
    localparam int VALUE_MIN      = -32768;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_LOW     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_HIGH    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INVERT_MASK = 2'd2;

    localparam logic CMD_TRACK = 1'b0;
    localparam logic CMD_MAP   = 1'b1;

    localparam logic signed [VALUE_BITS-1:0] OUT_LOW_RESET   = 16'sd0;
    localparam logic signed [VALUE_BITS-1:0] OUT_HIGH_RESET  = 16'sd1023;
    localparam logic [INVERT_BITS-1:0]       INVERT_RESET    = 6'd7;

endpackage

>>> src/smmc_if.sv
// Sample and result channel interfaces with valid/ready handshake.
interface smmc_sample_if
    import smmc_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
);
    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic [CHANNEL_BITS-1:0] channel;
    logic [SAMPLE_BITS-1:0]  sample;

    modport source (output valid, cmd, channel, sample, input ready);
    modport sink   (input valid, cmd, channel, sample, output ready);
endinterface

interface smmc_result_if
    import smmc_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_BITS-1:0]  mapped_value;
    logic                          span_zero;
    logic [SAMPLE_BITS-1:0]        channel_max;
    logic [SAMPLE_BITS-1:0]        channel_min;

    modport source (output valid, mapped_value, span_zero, channel_max, channel_min,
                    input ready);
    modport sink   (input valid, mapped_value, span_zero, channel_max, channel_min,
                    output ready);
endinterface

>>> src/smmc_front.sv
// Front end: accepts samples, applies inversion and tracks per-channel extremes.
module smmc_front
    import smmc_pkg::*;
#(
    parameter int CHANNELS    = 6,
    parameter int SAMPLE_BITS = 10
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    smmc_sample_if.sink                sample_ch,
    input  logic [INVERT_BITS-1:0]     invert_mask,
    output logic                       job_valid,
    input  logic                       job_ready,
    output logic [2+3*SAMPLE_BITS-1:0] job_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef struct packed {
        logic                   do_div;
        logic                   span_zero;
        logic [SAMPLE_BITS-1:0] sample;
        logic [SAMPLE_BITS-1:0] ch_max;
        logic [SAMPLE_BITS-1:0] ch_min;
    } job_t;

    logic [SAMPLE_BITS-1:0] store_max_reg [CHANNELS];
    logic [SAMPLE_BITS-1:0] store_min_reg [CHANNELS];
    logic [SAMPLE_BITS-1:0] store_max_next;
    logic [SAMPLE_BITS-1:0] store_min_next;

    logic [IDX_W+CHANNEL_BITS-1:0] ch_ext;
    logic [IDX_W-1:0]              safe_idx;
    logic [CHANNEL_CODES-1:0]      inv_ext;
    logic                          ch_ok;
    logic                          accept;
    logic                          track_wr;
    logic [SAMPLE_BITS-1:0]        s;
    logic [SAMPLE_BITS-1:0]        cur_max;
    logic [SAMPLE_BITS-1:0]        cur_min;
    job_t                          job;

    always_comb
    begin
        ch_ext   = {{IDX_W{1'b0}}, sample_ch.channel};
        ch_ok    = {{(32-CHANNEL_BITS){1'b0}}, sample_ch.channel} < 32'(CHANNELS);
        safe_idx = ch_ok ? ch_ext[IDX_W-1:0] : '0;
        inv_ext  = {{(CHANNEL_CODES-INVERT_BITS){1'b0}}, invert_mask};
        s        = inv_ext[sample_ch.channel] ? ~sample_ch.sample : sample_ch.sample;
        cur_max  = store_max_reg[safe_idx];
        cur_min  = store_min_reg[safe_idx];
        store_max_next = (s > cur_max) ? s : cur_max;
        store_min_next = (s < cur_min) ? s : cur_min;

        job = '0;
        if (ch_ok)
        begin
            if (sample_ch.cmd == CMD_MAP)
            begin
                job.span_zero = (cur_max == cur_min);
                job.do_div    = (cur_max != cur_min);
                job.sample    = s;
                job.ch_max    = cur_max;
                job.ch_min    = cur_min;
            end
            else
            begin
                job.ch_max = store_max_next;
                job.ch_min = store_min_next;
            end
        end
    end

    assign accept          = sample_ch.valid && job_ready;
    assign track_wr        = accept && ch_ok && (sample_ch.cmd == CMD_TRACK);
    assign sample_ch.ready = job_ready;
    assign job_valid       = sample_ch.valid;
    assign job_data        = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                store_max_reg[i] <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                store_min_reg[i] <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            end
        end
        else if (track_wr)
        begin
            store_max_reg[safe_idx] <= store_max_next;
            store_min_reg[safe_idx] <= store_min_next;
        end
    end

    // Tracking can only widen the range, so the minimum never passes the maximum.
    a_track_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        track_wr |=> store_max_reg[$past(safe_idx)] >= store_min_reg[$past(safe_idx)])
        else $error("channel minimum exceeds maximum after tracking");

endmodule

>>> src/smmc_queue.sv
// Small FIFO that decouples the front end from the arithmetic back end.
module smmc_queue
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

endmodule

>>> src/smmc_back.sv
// Back end: multiplies, divides two quotient bits per cycle and saturates the result.
module smmc_back
    import smmc_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_valid,
    output logic                         job_ready,
    input  logic [2+3*SAMPLE_BITS-1:0]   job_data,
    input  logic signed [VALUE_BITS-1:0] out_low,
    input  logic signed [VALUE_BITS-1:0] out_high,
    smmc_result_if.source                result_ch
);

    localparam int SB    = SAMPLE_BITS;
    localparam int NW    = SB + VALUE_BITS;
    localparam int ITER  = (NW + 1) / 2;
    localparam int DW    = 2 * ITER;
    localparam int CNT_W = $clog2(ITER + 1);
    localparam int SUM_W = DW + 2;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(VALUE_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(VALUE_MIN);

    typedef struct packed {
        logic          do_div;
        logic          span_zero;
        logic [SB-1:0] sample;
        logic [SB-1:0] ch_max;
        logic [SB-1:0] ch_min;
    } job_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    job_t                    job_in;
    job_t                    job_reg, job_next;
    logic                    neg_reg, neg_next;
    logic [SB-1:0]           dvs_reg, dvs_next;
    logic [SB-1:0]           rem_reg, rem_next;
    logic [DW-1:0]           quo_reg, quo_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0]   mapped_reg, mapped_next;
    logic                    zero_reg, zero_next;
    logic [SB-1:0]           max_reg, max_next;
    logic [SB-1:0]           min_reg, min_next;

    logic                    out_free;
    logic                    pop;
    logic [SB:0]             diff, diff_abs, span, span_abs;
    logic [VALUE_BITS:0]     rng, rng_abs;
    logic [NW-1:0]           prod;
    logic [SB:0]             t1, t2, r1, r2;
    logic                    ge1, ge2;
    logic [DW:0]             q_ext, q_signed;
    logic signed [SUM_W-1:0] sum;
    logic [VALUE_BITS-1:0]   sat;

    assign job_in    = job_data;
    assign out_free  = !out_valid_reg || result_ch.ready;
    assign pop       = (state_reg == ST_IDLE) && job_valid && (job_in.do_div || out_free);
    assign job_ready = pop;

    always_comb
    begin
        diff     = {1'b0, job_reg.sample} - {1'b0, job_reg.ch_min};
        diff_abs = diff[SB] ? (~diff + 1'b1) : diff;
        span     = {1'b0, job_reg.ch_max} - {1'b0, job_reg.ch_min};
        span_abs = span[SB] ? (~span + 1'b1) : span;
        rng      = {out_high[VALUE_BITS-1], out_high} - {out_low[VALUE_BITS-1], out_low};
        rng_abs  = rng[VALUE_BITS] ? (~rng + 1'b1) : rng;
        prod     = NW'(diff_abs[SB-1:0]) * NW'(rng_abs[VALUE_BITS-1:0]);

        t1  = {rem_reg, quo_reg[DW-1]};
        ge1 = (t1 >= {1'b0, dvs_reg});
        r1  = ge1 ? (t1 - {1'b0, dvs_reg}) : t1;
        t2  = {r1[SB-1:0], quo_reg[DW-2]};
        ge2 = (t2 >= {1'b0, dvs_reg});
        r2  = ge2 ? (t2 - {1'b0, dvs_reg}) : t2;

        q_ext    = {1'b0, quo_reg};
        q_signed = neg_reg ? (~q_ext + 1'b1) : q_ext;
        sum      = $signed({q_signed[DW], q_signed}) + SUM_W'(out_low);
        if (sum > SAT_HI)
        begin
            sat = VALUE_BITS'(VALUE_MAX);
        end
        else if (sum < SAT_LO)
        begin
            sat = VALUE_BITS'(VALUE_MIN);
        end
        else
        begin
            sat = sum[VALUE_BITS-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        neg_next       = neg_reg;
        dvs_next       = dvs_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !result_ch.ready;
        mapped_next    = mapped_reg;
        zero_next      = zero_reg;
        max_next       = max_reg;
        min_next       = min_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    if (job_in.do_div)
                    begin
                        job_next   = job_in;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        mapped_next    = job_in.span_zero ? out_low : '0;
                        zero_next      = job_in.span_zero;
                        max_next       = job_in.ch_max;
                        min_next       = job_in.ch_min;
                    end
                end
            end
            ST_MUL:
            begin
                neg_next   = diff[SB] ^ rng[VALUE_BITS] ^ span[SB];
                dvs_next   = span_abs[SB-1:0];
                rem_next   = '0;
                quo_next   = DW'(prod);
                cnt_next   = CNT_W'(ITER);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = r2[SB-1:0];
                quo_next = {quo_reg[DW-3:0], ge1, ge2};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    mapped_next    = sat;
                    zero_next      = 1'b0;
                    max_next       = job_reg.ch_max;
                    min_next       = job_reg.ch_min;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        neg_reg    <= neg_next;
        dvs_reg    <= dvs_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        mapped_reg <= mapped_next;
        zero_reg   <= zero_next;
        max_reg    <= max_next;
        min_reg    <= min_next;
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.mapped_value = mapped_reg;
    assign result_ch.span_zero    = zero_reg;
    assign result_ch.channel_max  = max_reg;
    assign result_ch.channel_min  = min_reg;

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> dvs_reg != '0)
        else $error("divide started with a zero span");

    a_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |-> rem_reg < dvs_reg)
        else $error("final remainder not below divisor");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> (state_reg == ST_DIV) && (cnt_reg == CNT_W'(ITER)))
        else $error("divide did not start with a full step count");

endmodule

>>> src/sensor_min_max_calibrate_map.sv
// Top level of the per-channel sensor min/max calibration and mapping block.
// Track, zero-span and out-of-range items bypass the divider and are answered from idle.
// Map items pass through the multiply step and the two-bits-per-cycle divider loop; the
// back end takes no new item until the map item in flight has left its done state.
// The front end takes one beat per cycle while the two-entry queue has room.
// Reset (asynchronous, active low) sets every stored extreme to half scale and the
// registers to their defaults at once; no clearing pass is needed.
module sensor_min_max_calibrate_map
    import smmc_pkg::*;
#(
    parameter int CHANNELS    = 6,
    parameter int SAMPLE_BITS = 10
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    smmc_sample_if.sink               sample_ch,
    smmc_result_if.source             result_ch,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [VALUE_BITS-1:0]     cfg_data
);

    localparam int JOB_W = 2 + 3 * SAMPLE_BITS;

    logic signed [VALUE_BITS-1:0] out_low_reg;
    logic signed [VALUE_BITS-1:0] out_high_reg;
    logic [INVERT_BITS-1:0]       invert_mask_reg;

    logic             job_valid;
    logic             job_ready;
    logic [JOB_W-1:0] job_data;
    logic             q_valid;
    logic             q_ready;
    logic [JOB_W-1:0] q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_low_reg     <= OUT_LOW_RESET;
            out_high_reg    <= OUT_HIGH_RESET;
            invert_mask_reg <= INVERT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OUT_LOW:     out_low_reg     <= cfg_data;
                REG_OUT_HIGH:    out_high_reg    <= cfg_data;
                REG_INVERT_MASK: invert_mask_reg <= cfg_data[INVERT_BITS-1:0];
                default:         ;
            endcase
        end
    end

    smmc_front #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_ch   (sample_ch),
        .invert_mask (invert_mask_reg),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .job_data    (job_data)
    );

    smmc_queue #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (job_valid),
        .push_ready (job_ready),
        .push_data  (job_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    smmc_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job_data  (q_data),
        .out_low   (out_low_reg),
        .out_high  (out_high_reg),
        .result_ch (result_ch)
    );

endmodule

>>> tb/sv/smmc_checker.sv
// Checker for the sensor calibration block: predicts each result beat and compares it.
module smmc_checker
    import smmc_pkg::*;
#(
    parameter int CHANNELS    = 6,
    parameter int SAMPLE_BITS = 10
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    smmc_sample_if                    sample_mon,
    smmc_result_if                    result_mon,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [VALUE_BITS-1:0]     cfg_data,
    output int                        fail_count,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] mapped_value;
        logic                         span_zero;
        logic [SAMPLE_BITS-1:0]       channel_max;
        logic [SAMPLE_BITS-1:0]       channel_min;
    } calib_beat_t;

    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;
    localparam logic [SAMPLE_BITS-1:0] HALF_SCALE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [VALUE_BITS-1:0] low_reg;
    logic signed [VALUE_BITS-1:0] high_reg;
    logic [INVERT_BITS-1:0]       invert_reg;
    logic [SAMPLE_BITS-1:0]       max_mem [CHANNELS];
    logic [SAMPLE_BITS-1:0]       min_mem [CHANNELS];
    calib_beat_t                  calib_q [$];
    int                           mismatches;
    int                           ch_idx;
    calib_beat_t                  got;
    calib_beat_t                  want;

    function automatic calib_beat_t calibrate(input logic c,
                                              input logic [CHANNEL_BITS-1:0] ch,
                                              input logic [SAMPLE_BITS-1:0] raw);
        calib_beat_t            r;
        logic [SAMPLE_BITS-1:0] s;
        longint                 span;
        longint                 value;
        r = '0;
        if (ch < CHANNELS) begin
            s = invert_reg[ch] ? FULL_SCALE - raw : raw;
            if (c == CMD_TRACK) begin
                if (s > max_mem[ch])
                    max_mem[ch] = s;
                if (s < min_mem[ch])
                    min_mem[ch] = s;
            end
            else begin
                span = longint'(max_mem[ch]) - longint'(min_mem[ch]);
                if (span == 0) begin
                    r.mapped_value = low_reg;
                    r.span_zero    = 1'b1;
                end
                else begin
                    value = (longint'(s) - longint'(min_mem[ch]))
                          * (longint'(high_reg) - longint'(low_reg)) / span
                          + longint'(low_reg);
                    if (value > VALUE_MAX)
                        value = VALUE_MAX;
                    if (value < VALUE_MIN)
                        value = VALUE_MIN;
                    r.mapped_value = value[VALUE_BITS-1:0];
                end
            end
            r.channel_max = max_mem[ch];
            r.channel_min = min_mem[ch];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg    = OUT_LOW_RESET;
            high_reg   = OUT_HIGH_RESET;
            invert_reg = INVERT_RESET;
            for (ch_idx = 0; ch_idx < CHANNELS; ch_idx++)
            begin
                max_mem[ch_idx] = HALF_SCALE;
                min_mem[ch_idx] = HALF_SCALE;
            end
            calib_q.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OUT_LOW:     low_reg    = cfg_data;
                    REG_OUT_HIGH:    high_reg   = cfg_data;
                    REG_INVERT_MASK: invert_reg = cfg_data[INVERT_BITS-1:0];
                    default:         ;
                endcase
            end
            if (sample_mon.valid && sample_mon.ready)
                calib_q.push_back(calibrate(sample_mon.cmd, sample_mon.channel,
                                            sample_mon.sample));
            if (result_mon.valid && result_mon.ready)
            begin
                got.mapped_value = result_mon.mapped_value;
                got.span_zero    = result_mon.span_zero;
                got.channel_max  = result_mon.channel_max;
                got.channel_min  = result_mon.channel_min;
                if (calib_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing expected: ", $time,
                                 "value %0d zero %0b max %0d min %0d",
                                 got.mapped_value, got.span_zero,
                                 got.channel_max, got.channel_min);
                end
                else
                begin
                    want = calib_q.pop_front();
                    if (got.mapped_value !== want.mapped_value
                        || got.span_zero !== want.span_zero
                        || got.channel_max !== want.channel_max
                        || got.channel_min !== want.channel_min)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: value %0d/%0d zero %0b/%0b", $time,
                                     want.mapped_value, got.mapped_value,
                                     want.span_zero, got.span_zero,
                                     " max %0d/%0d min %0d/%0d (expected/actual)",
                                     want.channel_max, got.channel_max,
                                     want.channel_min, got.channel_min);
                    end
                end
            end
        end
        fail_count <= mismatches;
        pending    <= calib_q.size();
    end

endmodule

>>> tb/sv/tb_top.sv
// Top of the calibration block testbench: clock, reset, stimulus, back pressure and verdict.
module tb_top
    import smmc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CHANNELS   = 6;
    localparam int SAMPLE_BITS    = 10;
    localparam int RESULT_LATENCY = 30;
    localparam int HOLD_CYCLES    = 150;
    localparam int STALL_LIMIT    = 5000;
    localparam int SEGMENT_ITEMS  = 275;
    localparam int SEGMENTS       = 6;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED = 2'd3;

    logic                      clk   = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [VALUE_BITS-1:0]     cfg_data;
    int                        fail_count;
    int                        pending;
    int                        send_idle_pct = 25;
    int                        recv_idle_pct = 66;
    int                        hold_requests = 0;
    int                        holds_served  = 0;
    int                        hold_left     = 0;
    int                        stall_cycles  = 0;
    int                        track_spread  = 4;

    smmc_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_bus ();
    smmc_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_bus ();

    sensor_min_max_calibrate_map #(
        .CHANNELS    (NUM_CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_bus),
        .result_ch (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    smmc_checker #(
        .CHANNELS    (NUM_CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_mon (sample_bus),
        .result_mon (result_bus),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left          <= hold_left - 1;
            result_bus.ready   <= 1'b0;
        end
        else if (hold_requests != holds_served)
        begin
            holds_served       <= holds_served + 1;
            hold_left          <= HOLD_CYCLES;
            result_bus.ready   <= 1'b0;
        end
        else
            result_bus.ready   <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_bus.valid && sample_bus.ready)
            || (result_bus.valid && result_bus.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_item(input logic c, input int ch, input int s);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_bus.valid <= 1'b0;
            @(negedge clk);
        end
        sample_bus.valid   <= 1'b1;
        sample_bus.cmd     <= c;
        sample_bus.channel <= ch[CHANNEL_BITS-1:0];
        sample_bus.sample  <= s[SAMPLE_BITS-1:0];
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        sample_bus.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[VALUE_BITS-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(input int lo, input int hi, input int mask);
        drain();
        repeat (RESULT_LATENCY) @(negedge clk);
        write_reg(REG_OUT_LOW, lo);
        write_reg(REG_OUT_HIGH, hi);
        write_reg(REG_INVERT_MASK, mask);
    endtask

    initial
    begin
        int   seg;
        int   n;
        int   ch;
        int   s;
        int   lo;
        int   hi;
        logic c;

        sample_bus.valid   = 1'b0;
        sample_bus.cmd     = CMD_TRACK;
        sample_bus.channel = '0;
        sample_bus.sample  = '0;
        result_bus.ready   = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_OUT_LOW;
        cfg_data           = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default registers: zero-span maps, out-of-range channels, full-scale tracking.
        send_item(CMD_MAP,   0, 0);
        send_item(CMD_MAP,   5, 1023);
        send_item(CMD_TRACK, 6, 1023);
        send_item(CMD_MAP,   7, 0);
        send_item(CMD_TRACK, 0, 0);
        send_item(CMD_TRACK, 0, 1023);
        send_item(CMD_MAP,   0, 0);
        send_item(CMD_MAP,   0, 1023);
        send_item(CMD_MAP,   0, 341);
        send_item(CMD_TRACK, 3, 700);
        send_item(CMD_MAP,   3, 1023);
        send_item(CMD_MAP,   3, 0);
        send_item(CMD_TRACK, 3, 300);

        drain();
        write_reg(REG_UNMAPPED, 16'hffff);
        configure(VALUE_MIN, VALUE_MAX, 16'hffc0);
        send_item(CMD_MAP,   3, 0);
        send_item(CMD_MAP,   3, 1023);
        send_item(CMD_MAP,   3, 512);
        send_item(CMD_TRACK, 1, 513);
        send_item(CMD_MAP,   1, 1023);
        send_item(CMD_MAP,   2, 512);

        configure(VALUE_MAX, VALUE_MIN, 16'h003f);
        send_item(CMD_MAP,   1, 510);
        send_item(CMD_MAP,   1, 0);
        send_item(CMD_MAP,   1, 1023);
        send_item(CMD_TRACK, 4, 1023);
        send_item(CMD_MAP,   4, 1023);

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == 0)
                configure(VALUE_MIN, VALUE_MAX, 16'h003f);
            else if (seg == 1)
                configure(VALUE_MAX, VALUE_MIN, 16'hffc0);
            else
            begin
                if ($urandom_range(1))
                begin
                    lo = $urandom_range(2048) - 1024;
                    hi = $urandom_range(2048) - 1024;
                end
                else
                begin
                    lo = $urandom_range(65535);
                    hi = $urandom_range(65535);
                end
                configure(lo, hi, $urandom_range(65535));
            end
            send_idle_pct = (seg < 2) ? 25 : (seg < 4) ? 66 : 0;
            recv_idle_pct = (seg < 2) ? 66 : (seg < 4) ? 25 : 0;
            for (n = 0; n < SEGMENT_ITEMS; n++)
            begin
                if (seg == 1 && n == 40)
                    hold_requests++;
                if (seg == 3 && n == 150)
                    drain();
                ch = ($urandom_range(99) < 8) ? $urandom_range(7, NUM_CHANNELS)
                                              : $urandom_range(NUM_CHANNELS - 1);
                c  = 1'($urandom_range(1));
                if (c == CMD_TRACK)
                begin
                    s = 512 + $urandom_range(2 * track_spread) - track_spread;
                    if (s < 0)
                        s = 0;
                    if (s > 1023)
                        s = 1023;
                    if (track_spread < 512 && n % 3 == 0)
                        track_spread++;
                end
                else if ($urandom_range(9) == 0)
                    s = $urandom_range(1) ? 1023 : 0;
                else
                    s = $urandom_range(1023);
                send_item(c, ch, s);
            end
        end

        drain();
        repeat (RESULT_LATENCY) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
